// ===== sv/spb_pkg.sv =====
// ----------------------------------------------------------------------------
// spb_pkg
// Shared types and codes for the per-thread slot binding pool.
// ----------------------------------------------------------------------------
package spb_pkg;

   // Command codes carried in the request word.
   localparam logic [1:0] CMD_GET      = 2'd0;
   localparam logic [1:0] CMD_RELEASE  = 2'd1;
   localparam logic [1:0] CMD_FREE_ALL = 2'd2;

   // Status codes carried in the response word.
   localparam logic [2:0] STS_EXISTING  = 3'd0;
   localparam logic [2:0] STS_NEW       = 3'd1;
   localparam logic [2:0] STS_EXHAUSTED = 3'd2;
   localparam logic [2:0] STS_RELEASED  = 3'd3;
   localparam logic [2:0] STS_NONE      = 3'd4;
   localparam logic [2:0] STS_ALL_FREED = 3'd5;

   // Request word.
   typedef struct packed {
      logic [1:0] cmd;
      logic [3:0] requester_id;
   } spb_req_type;

   // Response word.
   typedef struct packed {
      logic [3:0] slot_index;
      logic [2:0] status;
      logic [4:0] free_count;
   } spb_rsp_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SWEEP,
      ST_FINISH
   } spb_state_type;

endpackage

// ===== sv/per_thread_slot_binding_pool.sv =====
// ----------------------------------------------------------------------------
// per_thread_slot_binding_pool
// Hands out slots to requesters from a LIFO free stack and keeps one binding
// per requester.
// ----------------------------------------------------------------------------
// In a get, a release or an unused command the accept cycle reads the free
// stack RAM and the binding RAM, and the lookup state then uses the read
// data, writes the binding RAM on a new binding or the free stack RAM on a
// release, and loads the response register once that register is free. A
// free-all walks the slot-bound flags one slot a cycle and pushes each bound
// slot through the single write port of the free stack RAM. The response
// register lets the next request word be accepted while a finished response
// still waits to be taken. Free stack entries not yet written since reset
// read as their own index, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module per_thread_slot_binding_pool #(
   parameter int NUM_SLOTS      = 16,
   parameter int NUM_REQUESTERS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  spb_pkg::spb_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output spb_pkg::spb_rsp_type rsp_data
);

   import spb_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int TOP_W  = $clog2(NUM_SLOTS + 1);
   localparam int RID_W  = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

   // Control state.
   spb_state_type             state_ff, state_in;
   logic [TOP_W-1:0]          top_ff, top_in;
   logic [NUM_SLOTS-1:0]      bound_ff, bound_in;
   logic [NUM_SLOTS-1:0]      svld_ff, svld_in;
   logic [NUM_REQUESTERS-1:0] bvld_ff, bvld_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [1:0]                cmd_ff, cmd_in;
   logic [3:0]                rid_ff, rid_in;
   logic [SLOT_W-1:0]         pop_addr_ff, pop_addr_in;
   logic                      pop_vld_ff, pop_vld_in;
   logic [SLOT_W-1:0]         idx_ff, idx_in;
   spb_rsp_type               rsp_ff, rsp_in;

   // Memory ports.
   logic                      stk_wr_en;
   logic [SLOT_W-1:0]         stk_wr_addr;
   logic [SLOT_W-1:0]         stk_wr_data;
   logic                      stk_rd_en;
   logic [SLOT_W-1:0]         stk_rd_addr;
   logic [SLOT_W-1:0]         stk_rd_data;
   logic                      bnd_wr_en;
   logic [RID_W-1:0]          bnd_wr_addr;
   logic [SLOT_W-1:0]         bnd_wr_data;
   logic                      bnd_rd_en;
   logic [RID_W-1:0]          bnd_rd_addr;
   logic [SLOT_W-1:0]         bnd_rd_data;

   logic                      accept;
   logic                      out_free;
   logic                      rid_ok;
   logic [RID_W-1:0]          rid_idx;
   logic [SLOT_W-1:0]         popped;

   // Free stack: entry i holds the slot at stack depth i.
   spb_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (NUM_SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   // Binding table: the slot bound to each requester.
   spb_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (NUM_REQUESTERS)
   ) u_binding_ram (
      .clock   (clock),
      .wr_en   (bnd_wr_en),
      .wr_addr (bnd_wr_addr),
      .wr_data (bnd_wr_data),
      .rd_en   (bnd_rd_en),
      .rd_addr (bnd_rd_addr),
      .rd_data (bnd_rd_data)
   );

   // Handshake.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Decode of the held request.
   assign rid_ok  = 32'(rid_ff) < NUM_REQUESTERS;
   assign rid_idx = RID_W'(32'(rid_ff));
   assign popped  = pop_vld_ff ? stk_rd_data : pop_addr_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.cmd == CMD_FREE_ALL) ? ST_SWEEP : ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory accesses and response.
   always_comb begin
      top_in       = top_ff;
      bound_in     = bound_ff;
      svld_in      = svld_ff;
      bvld_in      = bvld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd_in       = cmd_ff;
      rid_in       = rid_ff;
      pop_addr_in  = pop_addr_ff;
      pop_vld_in   = pop_vld_ff;
      idx_in       = idx_ff;

      stk_wr_en    = 1'b0;
      stk_wr_addr  = SLOT_W'(top_ff);
      stk_wr_data  = idx_ff;
      stk_rd_en    = 1'b0;
      stk_rd_addr  = SLOT_W'(top_ff - TOP_W'(1));
      bnd_wr_en    = 1'b0;
      bnd_wr_addr  = rid_idx;
      bnd_wr_data  = popped;
      bnd_rd_en    = 1'b0;
      bnd_rd_addr  = RID_W'(32'(req_data.requester_id));

      unique case (state_ff)
         // Take the word and start both reads.
         ST_IDLE: begin
            if (accept) begin
               cmd_in      = req_data.cmd;
               rid_in      = req_data.requester_id;
               stk_rd_en   = 1'b1;
               bnd_rd_en   = 1'b1;
               pop_addr_in = stk_rd_addr;
               pop_vld_in  = svld_ff[stk_rd_addr];
               idx_in      = '0;
               if (req_data.cmd == CMD_FREE_ALL) begin
                  bvld_in = '0;
               end
            end
         end

         // Use the read data, write back and load the response.
         ST_LOOKUP: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.slot_index = '0;
               rsp_in.status     = STS_NONE;
               case (cmd_ff)
                  CMD_GET: begin
                     if (rid_ok && bvld_ff[rid_idx]) begin
                        rsp_in.slot_index = 4'(32'(bnd_rd_data));
                        rsp_in.status     = STS_EXISTING;
                     end else if (!rid_ok || top_ff == '0) begin
                        rsp_in.status = STS_EXHAUSTED;
                     end else begin
                        top_in            = top_ff - TOP_W'(1);
                        bound_in[popped]  = 1'b1;
                        bvld_in[rid_idx]  = 1'b1;
                        bnd_wr_en         = 1'b1;
                        rsp_in.slot_index = 4'(32'(popped));
                        rsp_in.status     = STS_NEW;
                     end
                  end
                  CMD_RELEASE: begin
                     if (rid_ok && bvld_ff[rid_idx]) begin
                        bvld_in[rid_idx]      = 1'b0;
                        bound_in[bnd_rd_data] = 1'b0;
                        if (32'(top_ff) < NUM_SLOTS) begin
                           stk_wr_en            = 1'b1;
                           stk_wr_data          = bnd_rd_data;
                           svld_in[stk_wr_addr] = 1'b1;
                           top_in               = top_ff + TOP_W'(1);
                        end
                        rsp_in.slot_index = 4'(32'(bnd_rd_data));
                        rsp_in.status     = STS_RELEASED;
                     end
                  end
                  default: begin
                     rsp_in.status = STS_NONE;
                  end
               endcase
               rsp_in.free_count = 5'(32'(top_in));
            end
         end

         // Push each bound slot in ascending order.
         ST_SWEEP: begin
            idx_in = idx_ff + SLOT_W'(1);
            if (bound_ff[idx_ff]) begin
               bound_in[idx_ff] = 1'b0;
               if (32'(top_ff) < NUM_SLOTS) begin
                  stk_wr_en            = 1'b1;
                  stk_wr_data          = idx_ff;
                  svld_in[stk_wr_addr] = 1'b1;
                  top_in               = top_ff + TOP_W'(1);
               end
            end
         end

         // Report the free-all.
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.slot_index = '0;
               rsp_in.status     = STS_ALL_FREED;
               rsp_in.free_count = 5'(32'(top_ff));
            end
         end

         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         top_ff       <= TOP_W'(NUM_SLOTS);
         bound_ff     <= '0;
         svld_ff      <= '0;
         bvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         bound_ff     <= bound_in;
         svld_ff      <= svld_in;
         bvld_ff      <= bvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rid_ff      <= rid_in;
      pop_addr_ff <= pop_addr_in;
      pop_vld_ff  <= pop_vld_in;
      idx_ff      <= idx_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// ===== sv/spb_ram.sv =====
// ----------------------------------------------------------------------------
// spb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
